@@ sv/pks_pkg.sv @@
// Shared types, register codes and arithmetic helpers for the particle step pipeline.
`default_nettype none
package pks_pkg;

    typedef logic signed [31:0] q_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_DIR_X     = 3'd0,
        REG_DIR_Y     = 3'd1,
        REG_DIR_Z     = 3'd2,
        REG_ACCEL_MAG = 3'd3,
        REG_FORCE_X   = 3'd4,
        REG_FORCE_Y   = 3'd5,
        REG_FORCE_Z   = 3'd6,
        REG_ATTRACT   = 3'd7
    } reg_idx_t;

    localparam int ROOT_STAGES = 16;  // two root iterations per stage
    localparam int DIV_STEPS   = 17;  // quotient bits of the unit vector
    localparam int DIV_STAGES  = 9;   // two quotient bits per stage, one in the last
    localparam int FRONT_STAGES = 4;
    localparam int BACK_STAGES  = 4;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;
    localparam q_t Q_MAX = 32'sh7fffffff;
    localparam q_t Q_MIN = 32'sh80000000;

    // Everything one particle carries down the pipe
    typedef struct packed {
        q_t [2:0]              pos;
        q_t [2:0]              vel;
        q_t [2:0]              acc;
        logic [15:0]           t;
        logic [31:0]           tt;
        logic                  att;
        logic [2:0]            neg;
        logic [2:0][31:0]      mag;
        logic [2:0][63:0]      prod;
        logic [63:0]           rem;
        logic [63:0]           root;
        logic [2:0][31:0]      drem;
        logic [2:0][16:0]      quot;
        logic [2:0][49:0]      gprod;
        logic [2:0][48:0]      vt;
        logic [2:0][48:0]      at;
        logic [2:0][64:0]      att2;
    } item_t;

    function automatic q_t sat32(input logic signed [65:0] x);
        if (x > SAT_MAX) begin
            return Q_MAX;
        end else if (x < SAT_MIN) begin
            return Q_MIN;
        end
        return q_t'(x[31:0]);
    endfunction

    // One iteration of the bit-pair square root
    function automatic item_t root_step(input item_t x, input logic [63:0] bw);
        item_t       y;
        logic [63:0] trial;
        y     = x;
        trial = x.root + bw;
        if (x.rem >= trial) begin
            y.rem  = x.rem - trial;
            y.root = (x.root >> 1) + bw;
        end else begin
            y.root = x.root >> 1;
        end
        return y;
    endfunction

    // Load partial remainders: quotient stays below 2^17, so start at m >> 1
    function automatic item_t div_init(input item_t x);
        item_t y;
        y = x;
        for (int a = 0; a < 3; a++) begin
            y.drem[a] = x.mag[a] >> 1;
            y.quot[a] = '0;
        end
        return y;
    endfunction

    // One restoring step on all three axes; only the first step shifts in a data bit
    function automatic item_t div_step(input item_t x, input logic first);
        item_t       y;
        logic [32:0] len;
        logic [32:0] r2;
        logic [32:0] diff;
        y   = x;
        len = {1'b0, x.root[31:0]};
        for (int a = 0; a < 3; a++) begin
            r2   = {x.drem[a], first & x.mag[a][0]};
            diff = r2 - len;
            if (r2 >= len) begin
                y.drem[a] = diff[31:0];
                y.quot[a] = {x.quot[a][15:0], 1'b1};
            end else begin
                y.drem[a] = r2[31:0];
                y.quot[a] = {x.quot[a][15:0], 1'b0};
            end
        end
        return y;
    endfunction

endpackage
`default_nettype wire

@@ sv/particle_kinematic_step.sv @@
// Top level: constant-acceleration particle update, fully pipelined.
//
// Input channel s_*: one particle word per handshake (position, velocity,
// attractor flag and origin, frame time). Output channel m_*: the updated
// position and velocity of that particle, in the same order as accepted.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (direction, accel magnitude, force, attract strength); write only while
// the pipe is empty.
// Stages from acceptance to m_valid: 4 front stages, 16 square
// root stages, 9 divider stages, 4 back stages.
// Throughput: one word per cycle unless m_ready stalls; every stage holds one particle.
// Each stage moves when it is empty or the stage after it moves, so a stall
// on m_ready fills bubbles first and only then drops s_ready; nothing is
// lost or repeated. A stalled output word holds its value.
// Reset (aresetn low, synchronous) clears all valid bits and the
// configuration registers; s_ready is high right after reset.
`default_nettype none
module particle_kinematic_step (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  pks_pkg::q_t  cfg_wdata,
    // particle in
    input  logic         s_valid,
    output logic         s_ready,
    input  pks_pkg::q_t  s_pos_x,
    input  pks_pkg::q_t  s_pos_y,
    input  pks_pkg::q_t  s_pos_z,
    input  pks_pkg::q_t  s_vel_x,
    input  pks_pkg::q_t  s_vel_y,
    input  pks_pkg::q_t  s_vel_z,
    input  logic         s_attract_on,
    input  pks_pkg::q_t  s_origin_x,
    input  pks_pkg::q_t  s_origin_y,
    input  pks_pkg::q_t  s_origin_z,
    input  logic [15:0]  s_frame_time,
    // particle out
    output logic         m_valid,
    input  logic         m_ready,
    output pks_pkg::q_t  m_new_pos_x,
    output pks_pkg::q_t  m_new_pos_y,
    output pks_pkg::q_t  m_new_pos_z,
    output pks_pkg::q_t  m_new_vel_x,
    output pks_pkg::q_t  m_new_vel_y,
    output pks_pkg::q_t  m_new_vel_z
);
    import pks_pkg::*;

    // ---------------- configuration registers ----------------
    q_t dir_x_reg, dir_y_reg, dir_z_reg, accel_mag_reg;
    q_t force_x_reg, force_y_reg, force_z_reg, attract_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_x_reg     <= '0;
            dir_y_reg     <= '0;
            dir_z_reg     <= '0;
            accel_mag_reg <= '0;
            force_x_reg   <= '0;
            force_y_reg   <= '0;
            force_z_reg   <= '0;
            attract_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_DIR_X:     dir_x_reg     <= cfg_wdata;
                REG_DIR_Y:     dir_y_reg     <= cfg_wdata;
                REG_DIR_Z:     dir_z_reg     <= cfg_wdata;
                REG_ACCEL_MAG: accel_mag_reg <= cfg_wdata;
                REG_FORCE_X:   force_x_reg   <= cfg_wdata;
                REG_FORCE_Y:   force_y_reg   <= cfg_wdata;
                REG_FORCE_Z:   force_z_reg   <= cfg_wdata;
                REG_ATTRACT:   attract_reg   <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    q_t dir_v   [3];
    q_t force_v [3];
    q_t pos_in  [3];
    q_t vel_in  [3];
    q_t org_in  [3];

    assign dir_v   = '{dir_x_reg, dir_y_reg, dir_z_reg};
    assign force_v = '{force_x_reg, force_y_reg, force_z_reg};
    assign pos_in  = '{s_pos_x, s_pos_y, s_pos_z};
    assign vel_in  = '{s_vel_x, s_vel_y, s_vel_z};
    assign org_in  = '{s_origin_x, s_origin_y, s_origin_z};

    // ---------------- front stages ----------------
    item_t f1_reg, f2_reg, f3_reg, f4_reg;
    item_t f1_next, f2_next, f3_next, f4_next;
    logic [FRONT_STAGES-1:0] fv_reg, fv_in, fr_rdy;
    logic  root_in_ready;

    // F1: direction products, offset to attractor, t squared
    always_comb begin : f1_comb
        logic signed [63:0] pr;
        logic signed [32:0] dif;
        logic signed [32:0] adif;
        f1_next = '0;
        for (int a = 0; a < 3; a++) begin
            pr   = $signed(dir_v[a]) * $signed(accel_mag_reg);
            dif  = $signed({org_in[a][31], org_in[a]}) - $signed({pos_in[a][31], pos_in[a]});
            adif = dif[32] ? -dif : dif;
            f1_next.prod[a] = pr;
            f1_next.neg[a]  = dif[32];
            f1_next.mag[a]  = adif[31:0];
            f1_next.pos[a]  = pos_in[a];
            f1_next.vel[a]  = vel_in[a];
        end
        f1_next.t   = s_frame_time;
        f1_next.tt  = {16'b0, s_frame_time} * {16'b0, s_frame_time};
        f1_next.att = s_attract_on;
    end

    // F2: base acceleration; halve offsets if any is 2^31 or more
    always_comb begin : f2_comb
        logic signed [63:0] pr;
        q_t                 ad;
        logic               big;
        f2_next = f1_reg;
        big = f1_reg.mag[0][31] | f1_reg.mag[1][31] | f1_reg.mag[2][31];
        for (int a = 0; a < 3; a++) begin
            pr = $signed(f1_reg.prod[a]);
            ad = sat32(66'(pr >>> 16));
            f2_next.acc[a] = sat32(66'(ad) + 66'(force_v[a]));
            f2_next.mag[a] = big ? (f1_reg.mag[a] >> 1) : f1_reg.mag[a];
        end
    end

    // F3: squares
    always_comb begin
        f3_next = f2_reg;
        for (int a = 0; a < 3; a++) begin
            f3_next.prod[a] = {32'b0, f2_reg.mag[a]} * {32'b0, f2_reg.mag[a]};
        end
    end

    // F4: squared length, seed the root
    always_comb begin
        f4_next      = f3_reg;
        f4_next.rem  = f3_reg.prod[0] + f3_reg.prod[1] + f3_reg.prod[2];
        f4_next.root = '0;
    end

    always_comb begin
        fr_rdy[FRONT_STAGES-1] = !fv_reg[FRONT_STAGES-1] || root_in_ready;
        for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
            fr_rdy[k] = !fv_reg[k] || fr_rdy[k+1];
        end
    end

    assign fv_in   = {fv_reg[FRONT_STAGES-2:0], s_valid};
    assign s_ready = fr_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else begin
            for (int k = 0; k < FRONT_STAGES; k++) begin
                if (fr_rdy[k]) begin
                    fv_reg[k] <= fv_in[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fr_rdy[0]) f1_reg <= f1_next;
        if (fr_rdy[1]) f2_reg <= f2_next;
        if (fr_rdy[2]) f3_reg <= f3_next;
        if (fr_rdy[3]) f4_reg <= f4_next;
    end

    // ---------------- square root and divider ----------------
    item_t root_out, div_out;
    logic  root_out_valid, div_in_ready, div_out_valid, div_out_ready;

    pks_root_pipe u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fv_reg[FRONT_STAGES-1]),
        .in_ready  (root_in_ready),
        .in_item   (f4_reg),
        .out_valid (root_out_valid),
        .out_ready (div_in_ready),
        .out_item  (root_out)
    );

    pks_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (root_out_valid),
        .in_ready  (div_in_ready),
        .in_item   (root_out),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_item  (div_out)
    );

    // ---------------- back stages ----------------
    item_t b1_reg, b2_reg, b3_reg, b4_reg;
    item_t b1_next, b2_next, b3_next, b4_next;
    logic [BACK_STAGES-1:0] bv_reg, bv_in, bk_rdy;

    // B1: signed unit component times strength
    always_comb begin : b1_comb
        logic signed [17:0] u;
        logic signed [49:0] gp;
        b1_next = div_out;
        for (int a = 0; a < 3; a++) begin
            u  = div_out.neg[a] ? -$signed({1'b0, div_out.quot[a]})
                                :  $signed({1'b0, div_out.quot[a]});
            gp = u * $signed(attract_reg);
            b1_next.gprod[a] = gp;
        end
    end

    // B2: add attraction when enabled and the vector has length
    always_comb begin : b2_comb
        q_t   g;
        logic addg;
        b2_next = b1_reg;
        addg = b1_reg.att && (b1_reg.root[31:0] != '0);
        for (int a = 0; a < 3; a++) begin
            g = sat32(66'($signed(b1_reg.gprod[a]) >>> 16));
            if (addg) begin
                b2_next.acc[a] = sat32(66'($signed(b1_reg.acc[a])) + 66'(g));
            end
        end
    end

    // B3: v*t, a*t, a*t*t
    always_comb begin : b3_comb
        logic signed [48:0] vtp;
        logic signed [48:0] atp;
        logic signed [64:0] a2p;
        b3_next = b2_reg;
        for (int a = 0; a < 3; a++) begin
            vtp = $signed(b2_reg.vel[a]) * $signed({1'b0, b2_reg.t});
            atp = $signed(b2_reg.acc[a]) * $signed({1'b0, b2_reg.t});
            a2p = $signed(b2_reg.acc[a]) * $signed({1'b0, b2_reg.tt});
            b3_next.vt[a]   = vtp;
            b3_next.at[a]   = atp;
            b3_next.att2[a] = a2p;
        end
    end

    // B4: final sums, saturate once
    always_comb begin
        b4_next = b3_reg;
        for (int a = 0; a < 3; a++) begin
            b4_next.pos[a] = sat32(66'($signed(b3_reg.pos[a]))
                                 + 66'($signed(b3_reg.vt[a]) >>> 16)
                                 + 66'($signed(b3_reg.att2[a]) >>> 33));
            b4_next.vel[a] = sat32(66'($signed(b3_reg.vel[a]))
                                 + 66'($signed(b3_reg.at[a]) >>> 16));
        end
    end

    always_comb begin
        bk_rdy[BACK_STAGES-1] = !bv_reg[BACK_STAGES-1] || m_ready;
        for (int k = BACK_STAGES - 2; k >= 0; k--) begin
            bk_rdy[k] = !bv_reg[k] || bk_rdy[k+1];
        end
    end

    assign bv_in         = {bv_reg[BACK_STAGES-2:0], div_out_valid};
    assign div_out_ready = bk_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= '0;
        end else begin
            for (int k = 0; k < BACK_STAGES; k++) begin
                if (bk_rdy[k]) begin
                    bv_reg[k] <= bv_in[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bk_rdy[0]) b1_reg <= b1_next;
        if (bk_rdy[1]) b2_reg <= b2_next;
        if (bk_rdy[2]) b3_reg <= b3_next;
        if (bk_rdy[3]) b4_reg <= b4_next;
    end

    assign m_valid     = bv_reg[BACK_STAGES-1];
    assign m_new_pos_x = b4_reg.pos[0];
    assign m_new_pos_y = b4_reg.pos[1];
    assign m_new_pos_z = b4_reg.pos[2];
    assign m_new_vel_x = b4_reg.vel[0];
    assign m_new_vel_y = b4_reg.vel[1];
    assign m_new_vel_z = b4_reg.vel[2];

endmodule
`default_nettype wire

@@ sv/pks_root_pipe.sv @@
// Pipelined integer square root of the attraction vector's squared length.
`default_nettype none
module pks_root_pipe (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pks_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output pks_pkg::item_t out_item
);
    import pks_pkg::*;

    item_t                  stg_reg  [ROOT_STAGES];
    item_t                  stg_next [ROOT_STAGES];
    logic [ROOT_STAGES-1:0] vld_reg;
    logic [ROOT_STAGES-1:0] vld_in;
    logic [ROOT_STAGES-1:0] rdy;

    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stg
        localparam logic [63:0] BIT_A = 64'd1 << (62 - 4 * k);
        localparam logic [63:0] BIT_B = 64'd1 << (60 - 4 * k);
        item_t src;
        if (k == 0) begin : g_first
            assign src = in_item;
        end else begin : g_rest
            assign src = stg_reg[k-1];
        end
        assign stg_next[k] = root_step(root_step(src, BIT_A), BIT_B);
    end

    always_comb begin
        rdy[ROOT_STAGES-1] = !vld_reg[ROOT_STAGES-1] || out_ready;
        for (int k = ROOT_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_in = {vld_reg[ROOT_STAGES-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < ROOT_STAGES; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < ROOT_STAGES; k++) begin
            if (rdy[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[ROOT_STAGES-1];
    assign out_item  = stg_reg[ROOT_STAGES-1];

endmodule
`default_nettype wire

@@ sv/pks_div_pipe.sv @@
// Pipelined restoring divider forming the unit vector toward the attractor.
`default_nettype none
module pks_div_pipe (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pks_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output pks_pkg::item_t out_item
);
    import pks_pkg::*;

    item_t                 stg_reg  [DIV_STAGES];
    item_t                 stg_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] vld_in;
    logic [DIV_STAGES-1:0] rdy;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
        item_t src;
        item_t mid;
        if (k == 0) begin : g_first
            assign src = div_init(in_item);
        end else begin : g_rest
            assign src = stg_reg[k-1];
        end
        assign mid = div_step(src, (k == 0));
        if (2 * k + 1 < DIV_STEPS) begin : g_two
            assign stg_next[k] = div_step(mid, 1'b0);
        end else begin : g_one
            assign stg_next[k] = mid;
        end
    end

    always_comb begin
        rdy[DIV_STAGES-1] = !vld_reg[DIV_STAGES-1] || out_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_in = {vld_reg[DIV_STAGES-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (rdy[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_item  = stg_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ sv/pks_checker.sv @@
// Port-level checks for the particle step block and their bind.
`default_nettype none
module pks_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input pks_pkg::q_t m_new_pos_x,
    input pks_pkg::q_t m_new_pos_y,
    input pks_pkg::q_t m_new_pos_z,
    input pks_pkg::q_t m_new_vel_x,
    input pks_pkg::q_t m_new_vel_y,
    input pks_pkg::q_t m_new_vel_z
);
    // pipe is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) aresetn && !$past(aresetn) |-> !m_valid)
        else $error("output word valid right after reset");

    a_reset_ready: assert property (@(posedge aclk) aresetn && !$past(aresetn) |-> s_ready)
        else $error("input not ready right after reset");

    // a free output lets every stage move
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is taken");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_pos_x) && $stable(m_new_pos_y)
            && $stable(m_new_pos_z) && $stable(m_new_vel_x) && $stable(m_new_vel_y)
            && $stable(m_new_vel_z))
        else $error("stalled output word changed");

endmodule

bind particle_kinematic_step pks_checker u_pks_checker (.*);
`default_nettype wire
